// ===== rtl/ogs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ogs_pkg
// Shared widths, register map and types for the op-amp gain stage with clip.
// ----------------------------------------------------------------------------
package ogs_pkg;

  localparam int SAMPLE_W   = 24;   // Q3.20 signed
  localparam int GB_W       = 25;   // Q1.24 unsigned
  localparam int GI_W       = 24;   // Q8.16 unsigned
  localparam int CLIP_W     = 23;   // Q3.20 unsigned
  localparam int CAP_W      = 26;   // Q5.20 signed
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  localparam logic [GB_W-1:0]   GB_RESET   = 25'd16773188;
  localparam logic [GI_W-1:0]   GI_RESET   = 24'd130749;
  localparam logic [CLIP_W-1:0] CLIP_RESET = 23'd4718592;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GB   = 2'd0,
    CFG_GI   = 2'd1,
    CFG_CLIP = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [GB_W-1:0]   gb;
    logic [GI_W-1:0]   gi;
    logic [CLIP_W-1:0] clip_level;
  } cfg_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [CAP_W-1:0]    cap_t;

endpackage : ogs_pkg
`default_nettype wire

// ===== rtl/ogs_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ogs_cfg_regs
// Coefficient and clip level registers, written over the config channel.
// ----------------------------------------------------------------------------
module ogs_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ogs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ogs_pkg::CFG_DATA_W-1:0] cfg_data,
  output ogs_pkg::cfg_t                      cfg
);
  import ogs_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GB:   cfg_nxt.gb         = cfg_data[GB_W-1:0];
        CFG_GI:   cfg_nxt.gi         = cfg_data[GI_W-1:0];
        CFG_CLIP: cfg_nxt.clip_level = cfg_data[CLIP_W-1:0];
        default:  cfg_nxt = cfg_r;   // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gb         <= GB_RESET;
      cfg_r.gi         <= GI_RESET;
      cfg_r.clip_level <= CLIP_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule : ogs_cfg_regs
`default_nettype wire

// ===== rtl/ogs_cap_loop.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ogs_cap_loop
// Capacitor state recurrence: s' = sat(round(2^24*x + gb*(s-x), 23) - s).
// ----------------------------------------------------------------------------
module ogs_cap_loop (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire ogs_pkg::sample_t x,
  input  wire ogs_pkg::cfg_t    cfg,
  output ogs_pkg::cap_t         cap_state
);
  import ogs_pkg::*;

  localparam logic signed [CAP_W+5:0] CAP_MAX = 32'sd33554431;
  localparam logic signed [CAP_W+5:0] CAP_MIN = -32'sd33554432;

  cap_t                cap_state_r, cap_state_nxt;
  logic signed [26:0]  diff;
  logic signed [52:0]  prod;
  logic signed [53:0]  acc;
  logic signed [30:0]  rnd;
  logic signed [31:0]  ns;

  // round half away from zero, shift by 23
  function automatic logic signed [30:0] round23(input logic signed [53:0] v);
    logic signed [53:0] t;
    t = v + 54'sd4194304 - {53'd0, v[53]};
    return t[53:23];
  endfunction

  always_comb begin
    diff = {cap_state_r[CAP_W-1], cap_state_r} - {{3{x[SAMPLE_W-1]}}, x};
    prod = $signed({1'b0, cfg.gb}) * diff;
    acc  = {prod[52], prod} + {{6{x[SAMPLE_W-1]}}, x, 24'd0};
    rnd  = round23(acc);
    ns   = {rnd[30], rnd} - {{6{cap_state_r[CAP_W-1]}}, cap_state_r};
    priority if (ns > CAP_MAX) cap_state_nxt = CAP_MAX[CAP_W-1:0];
    else if (ns < CAP_MIN)     cap_state_nxt = CAP_MIN[CAP_W-1:0];
    else                       cap_state_nxt = ns[CAP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_state_r <= '0;
    end else if (adv) begin
      cap_state_r <= cap_state_nxt;
    end
  end

  assign cap_state = cap_state_r;

`ifndef SYNTHESIS
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(cap_state_r))
    else $error("cap state moved without a sample");
`endif

endmodule : ogs_cap_loop
`default_nettype wire

// ===== rtl/ogs_out_path.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ogs_out_path
// Output path: difference, gain multiply, round and hard clip, in three
// registered stages with per-stage flow control.
// ----------------------------------------------------------------------------
module ogs_out_path (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire ogs_pkg::sample_t x,
  input  wire ogs_pkg::cap_t    s,
  input  wire ogs_pkg::cfg_t    cfg,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [23:0]           out_tdata,   // [23:0] sample_out
  output logic                  out_tuser    // [0] clipped
);
  import ogs_pkg::*;

  logic               v1_r, v2_r, vo_r;
  logic               rdy1, rdy2, rdyo;
  logic signed [26:0] dx1_r;
  cap_t               s1_r;
  logic signed [52:0] p2_r, p2_nxt;
  logic signed [51:0] prod;
  logic signed [36:0] y;
  logic signed [36:0] clip_pos, clip_neg;
  sample_t            y_r, y_nxt;
  logic               clip_r, clip_nxt;

  function automatic logic signed [36:0] round16(input logic signed [52:0] v);
    logic signed [52:0] t;
    t = v + 53'sd32768 - {52'd0, v[52]};
    return t[52:16];
  endfunction

  assign rdyo     = !vo_r || out_tready;
  assign rdy2     = !v2_r || rdyo;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  // y = gi*(x - s) + 2^16*s
  always_comb begin
    prod   = $signed({1'b0, cfg.gi}) * dx1_r;
    p2_nxt = {prod[51], prod} + {{11{s1_r[CAP_W-1]}}, s1_r, 16'd0};
  end

  always_comb begin
    y        = round16(p2_r);
    clip_pos = {14'd0, cfg.clip_level};
    clip_neg = -clip_pos;
    priority if (y > clip_pos) begin
      y_nxt    = clip_pos[SAMPLE_W-1:0];
      clip_nxt = 1'b1;
    end else if (y < clip_neg) begin
      y_nxt    = clip_neg[SAMPLE_W-1:0];
      clip_nxt = 1'b1;
    end else begin
      y_nxt    = y[SAMPLE_W-1:0];
      clip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdyo) vo_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      dx1_r <= {{3{x[SAMPLE_W-1]}}, x} - {s[CAP_W-1], s};
      s1_r  <= s;
    end
    if (rdy2 && v1_r) p2_r <= p2_nxt;
    if (rdyo && v2_r) begin
      y_r    <= y_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = y_r;
  assign out_tuser  = clip_r;

`ifndef SYNTHESIS
  a_stage2_held: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && vo_r && !out_tready |=> v2_r && $stable(p2_r))
    else $error("stage 2 result lost under stall");
  a_stage1_held: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !rdy2 |=> v1_r && $stable(dx1_r))
    else $error("stage 1 item lost under stall");
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output transaction changed while stalled");
`endif

endmodule : ogs_out_path
`default_nettype wire

// ===== rtl/opamp_gain_stage_with_hard_clip.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// opamp_gain_stage_with_hard_clip
// Non-inverting op-amp gain stage (bilinear first-order IIR) with hard clip.
// ----------------------------------------------------------------------------
// Takes one signed Q3.20 sample per clock and returns one clipped sample per
// clock while the output is not stalled; a result is offered once its sample
// has passed four registers (input register, difference, gain product, round
// and clip). That rate is set by the capacitor state loop, which closes one
// 25x27 multiply, round and saturate through one register. Stalls on the
// output side back up stage by stage; empty stages keep accepting. Config
// writes are always taken and are meant for an idle block.
module opamp_gain_stage_with_hard_clip (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [23:0]                     in_tdata,    // [23:0] sample_in
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [23:0]                          out_tdata,   // [23:0] sample_out
  output logic                                 out_tuser,   // [0] clipped
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ogs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ogs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ogs_pkg::*;

  cfg_t    cfg;
  cap_t    cap_state;
  logic    v0_r;
  sample_t x0_r;
  logic    s1_ready;
  logic    adv;
  logic    in_fire;

  assign in_tready = !v0_r || s1_ready;
  assign in_fire   = in_tvalid && in_tready;
  assign adv       = v0_r && s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_tready) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) x0_r <= in_tdata;
  end

  ogs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ogs_cap_loop u_cap (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .x         (x0_r),
    .cfg       (cfg),
    .cap_state (cap_state)
  );

  ogs_out_path u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (v0_r),
    .up_ready   (s1_ready),
    .x          (x0_r),
    .s          (cap_state),
    .cfg        (cfg),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    v0_r && !s1_ready |=> v0_r && $stable(x0_r))
    else $error("input sample lost under stall");
`endif

endmodule : opamp_gain_stage_with_hard_clip
`default_nettype wire
